/* rtl/pltq_pkg.sv */
// Shared types and constants for the plate height query block.
// Used by pltq_ctrl, pltq_datapath and plate_height_query.
package pltq_pkg;

    localparam int MAX_PLATES_DEF = 256;

    localparam logic signed [31:0] SLOPE_UNIT_Q16 = 32'sd268406782;
    localparam logic signed [13:0] FLAT_LIMIT     = 14'sd4;

    // 46 quotient bits, two per cycle
    localparam int DIV_STEPS = 23;
    localparam int DCNT_W    = 5;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_LOAD = 12'b0000_0000_0010,
        S_RD   = 12'b0000_0000_0100,
        S_CHK  = 12'b0000_0000_1000,
        S_M0   = 12'b0000_0001_0000,
        S_M1   = 12'b0000_0010_0000,
        S_M2   = 12'b0000_0100_0000,
        S_ACC  = 12'b0000_1000_0000,
        S_PREP = 12'b0001_0000_0000,
        S_DIV  = 12'b0010_0000_0000,
        S_UPD  = 12'b0100_0000_0000,
        S_FIN  = 12'b1000_0000_0000
    } state_t;

    typedef enum logic [1:0] {
        MUL_PLANE = 2'd0,
        MUL_X     = 2'd1,
        MUL_Y     = 2'd2
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_NONE = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_SUB  = 2'd2
    } acc_op_t;

    typedef struct packed {
        logic     capture;
        logic     cnt_clr;
        logic     mem_wr;
        logic     rd;
        logic     walk_inc;
        logic     mul_en;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     div_init;
        logic     div_step;
        logic     upd;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic walk_done;
        logic hit_ok;
        logic div_last;
        logic out_busy;
    } status_t;

    typedef struct packed {
        logic signed [17:0] x0;
        logic signed [17:0] x1;
        logic signed [17:0] y0;
        logic signed [17:0] y1;
        logic signed [31:0] plane;
        logic signed [13:0] nx;
        logic signed [13:0] ny;
        logic signed [13:0] nz;
    } plate_t;

endpackage

/* rtl/pltq_ctrl.sv */
// Sequencer for the plate height query block.
// Depends on pltq_pkg; drives pltq_datapath through cmd_t / status_t.
module pltq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         op,
    input  pltq_pkg::status_t  status,
    output pltq_pkg::cmd_t     cmd
);

    pltq_pkg::state_t state_reg;
    pltq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pltq_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == pltq_pkg::S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.mul_sel  = pltq_pkg::MUL_PLANE;
        cmd.acc_op   = pltq_pkg::ACC_NONE;
        case (state_reg)
            pltq_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    case (op)
                        pltq_pkg::OP_LOAD:  state_next = pltq_pkg::S_LOAD;
                        pltq_pkg::OP_QUERY: state_next = pltq_pkg::S_RD;
                        pltq_pkg::OP_CLEAR:
                        begin
                            cmd.cnt_clr = 1'b1;
                            state_next  = pltq_pkg::S_FIN;
                        end
                        default:            state_next = pltq_pkg::S_FIN;
                    endcase
                end
            end
            pltq_pkg::S_LOAD:
            begin
                cmd.mem_wr = 1'b1;
                state_next = pltq_pkg::S_FIN;
            end
            pltq_pkg::S_RD:
            begin
                if (status.walk_done)
                    state_next = pltq_pkg::S_FIN;
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = pltq_pkg::S_CHK;
                end
            end
            pltq_pkg::S_CHK:
            begin
                if (status.hit_ok)
                    state_next = pltq_pkg::S_M0;
                else
                begin
                    cmd.walk_inc = 1'b1;
                    state_next   = pltq_pkg::S_RD;
                end
            end
            pltq_pkg::S_M0:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = pltq_pkg::MUL_PLANE;
                state_next  = pltq_pkg::S_M1;
            end
            pltq_pkg::S_M1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = pltq_pkg::MUL_X;
                cmd.acc_op  = pltq_pkg::ACC_LOAD;
                state_next  = pltq_pkg::S_M2;
            end
            pltq_pkg::S_M2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = pltq_pkg::MUL_Y;
                cmd.acc_op  = pltq_pkg::ACC_SUB;
                state_next  = pltq_pkg::S_ACC;
            end
            pltq_pkg::S_ACC:
            begin
                cmd.acc_op = pltq_pkg::ACC_SUB;
                state_next = pltq_pkg::S_PREP;
            end
            pltq_pkg::S_PREP:
            begin
                cmd.div_init = 1'b1;
                state_next   = pltq_pkg::S_DIV;
            end
            pltq_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = pltq_pkg::S_UPD;
            end
            pltq_pkg::S_UPD:
            begin
                cmd.upd      = 1'b1;
                cmd.walk_inc = 1'b1;
                state_next   = pltq_pkg::S_RD;
            end
            pltq_pkg::S_FIN:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = pltq_pkg::S_IDLE;
                end
            end
            default:
                state_next = pltq_pkg::S_IDLE;
        endcase
    end

    a_fin_release: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pltq_pkg::S_FIN && !status.out_busy) |=> state_reg == pltq_pkg::S_IDLE)
        else $error("result not released from FIN");

    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pltq_pkg::S_DIV && status.div_last) |=> state_reg == pltq_pkg::S_UPD)
        else $error("divider exit missed");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second transfer accepted while busy");

endmodule

/* rtl/pltq_datapath.sv */
// Plate table memory, shared multiplier, accumulator and radix-4 divider.
// Depends on pltq_pkg; sequenced by pltq_ctrl.
module pltq_datapath #(
    parameter int MAX_PLATES = pltq_pkg::MAX_PLATES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          op,
    input  logic signed [15:0]  plate_x,
    input  logic signed [15:0]  plate_y,
    input  logic signed [16:0]  plate_w,
    input  logic signed [16:0]  plate_h,
    input  logic signed [31:0]  plane_dist,
    input  logic signed [13:0]  normal_x,
    input  logic signed [13:0]  normal_y,
    input  logic signed [13:0]  normal_z,
    input  logic signed [31:0]  point_x,
    input  logic signed [31:0]  point_y,
    input  pltq_pkg::cmd_t      cmd,
    output pltq_pkg::status_t   status,
    output logic                found,
    output logic signed [31:0]  height,
    output logic                table_full,
    output logic                out_valid,
    input  logic                out_ready
);

    localparam int AW = (MAX_PLATES > 1) ? $clog2(MAX_PLATES) : 1;
    localparam int CW = $clog2(MAX_PLATES + 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_PLATES);

    pltq_pkg::plate_t mem [MAX_PLATES];
    pltq_pkg::plate_t rd_reg;
    pltq_pkg::plate_t new_plate;

    logic [1:0]         op_reg;
    logic signed [15:0] px_reg, py_reg;
    logic signed [16:0] pw_reg, ph_reg;
    logic signed [31:0] pd_reg;
    logic signed [13:0] nx_reg, ny_reg, nz_reg;
    logic signed [31:0] x_reg, y_reg;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] walk_reg;
    logic          tbl_full;

    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;

    logic               neg_reg;
    logic [29:0]        r_reg;
    logic [29:0]        dsor_reg;
    logic [45:0]        dq_reg;
    logic [pltq_pkg::DCNT_W-1:0] dcnt_reg;
    logic [29:0]        r_next;
    logic [45:0]        dq_next;

    logic               found_reg;
    logic signed [31:0] best_reg;
    logic               full_reg;
    logic signed [31:0] h_clamp;

    logic               out_valid_reg;
    logic               found_out_reg;
    logic signed [31:0] height_out_reg;
    logic               full_out_reg;

    logic signed [17:0] qx, qy, ex0, ex1;
    logic signed [33:0] xs, ys;
    logic               contain, flat;
    logic signed [63:0] abs_n;
    logic [13:0]        abs_z;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg <= op;
            px_reg <= plate_x;
            py_reg <= plate_y;
            pw_reg <= plate_w;
            ph_reg <= plate_h;
            pd_reg <= plane_dist;
            nx_reg <= normal_x;
            ny_reg <= normal_y;
            nz_reg <= normal_z;
            x_reg  <= point_x;
            y_reg  <= point_y;
        end
    end

    always_comb
    begin
        ex0 = 18'(px_reg);
        ex1 = 18'(py_reg);
        qx  = ex0 + 18'(pw_reg);
        qy  = ex1 + 18'(ph_reg);
        new_plate.x0    = (qx < ex0) ? qx : ex0;
        new_plate.x1    = (qx < ex0) ? ex0 : qx;
        new_plate.y0    = (qy < ex1) ? qy : ex1;
        new_plate.y1    = (qy < ex1) ? ex1 : qy;
        new_plate.plane = pd_reg;
        new_plate.nx    = nx_reg;
        new_plate.ny    = ny_reg;
        new_plate.nz    = nz_reg;
    end

    assign tbl_full = (count_reg == COUNT_MAX);

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr && !tbl_full)
            mem[count_reg[AW-1:0]] <= new_plate;
        if (cmd.rd)
            rd_reg <= mem[walk_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            walk_reg  <= '0;
        end
        else
        begin
            if (cmd.cnt_clr)
                count_reg <= '0;
            else if (cmd.mem_wr && !tbl_full)
                count_reg <= count_reg + 1'b1;
            if (cmd.capture)
                walk_reg <= '0;
            else if (cmd.walk_inc)
                walk_reg <= walk_reg + 1'b1;
        end
    end

    always_comb
    begin
        xs      = 34'(x_reg);
        ys      = 34'(y_reg);
        contain = (xs >= $signed({rd_reg.x0, 16'b0})) && (xs <= $signed({rd_reg.x1, 16'b0})) &&
                  (ys >= $signed({rd_reg.y0, 16'b0})) && (ys <= $signed({rd_reg.y1, 16'b0}));
        flat    = (rd_reg.nz >= -pltq_pkg::FLAT_LIMIT) && (rd_reg.nz <= pltq_pkg::FLAT_LIMIT);
    end

    always_comb
    begin
        case (cmd.mul_sel)
            pltq_pkg::MUL_PLANE:
            begin
                mul_a = rd_reg.plane;
                mul_b = pltq_pkg::SLOPE_UNIT_Q16;
            end
            pltq_pkg::MUL_X:
            begin
                mul_a = x_reg;
                mul_b = 32'(rd_reg.nx);
            end
            pltq_pkg::MUL_Y:
            begin
                mul_a = y_reg;
                mul_b = 32'(rd_reg.ny);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
            prod_reg <= 64'(mul_a) * 64'(mul_b);
        case (cmd.acc_op)
            pltq_pkg::ACC_LOAD: acc_reg <= prod_reg;
            pltq_pkg::ACC_SUB:  acc_reg <= acc_reg - (prod_reg <<< 16);
            default:            acc_reg <= acc_reg;
        endcase
    end

    assign abs_n = acc_reg[63] ? -acc_reg : acc_reg;
    assign abs_z = rd_reg.nz[13] ? 14'(-rd_reg.nz) : 14'(rd_reg.nz);

    always_comb
    begin
        logic [30:0] t;
        r_next  = r_reg;
        dq_next = dq_reg;
        for (int k = 0; k < 2; k++)
        begin
            t       = {r_next, dq_next[45]};
            dq_next = {dq_next[44:0], 1'b0};
            if (t >= {1'b0, dsor_reg})
            begin
                t          = t - {1'b0, dsor_reg};
                dq_next[0] = 1'b1;
            end
            r_next = t[29:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dcnt_reg <= '0;
        else if (cmd.div_init)
            dcnt_reg <= '0;
        else if (cmd.div_step)
            dcnt_reg <= dcnt_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            neg_reg  <= acc_reg[63] ^ rd_reg.nz[13];
            r_reg    <= 30'(abs_n[62:46]);
            dq_reg   <= abs_n[45:0];
            dsor_reg <= {abs_z, 16'b0};
        end
        else if (cmd.div_step)
        begin
            r_reg  <= r_next;
            dq_reg <= dq_next;
        end
    end

    always_comb
    begin
        if (!neg_reg)
            h_clamp = (dq_reg > 46'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(dq_reg[31:0]);
        else
            h_clamp = (dq_reg > 46'h8000_0000) ? 32'sh8000_0000 : -$signed(dq_reg[31:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            best_reg  <= '0;
            full_reg  <= 1'b0;
        end
        else if (cmd.capture)
        begin
            found_reg <= 1'b0;
            best_reg  <= '0;
            full_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.mem_wr && tbl_full)
                full_reg <= 1'b1;
            if (cmd.upd && (!found_reg || h_clamp > best_reg))
            begin
                found_reg <= 1'b1;
                best_reg  <= h_clamp;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            found_out_reg  <= found_reg && (op_reg == pltq_pkg::OP_QUERY);
            height_out_reg <= (op_reg == pltq_pkg::OP_QUERY) ? best_reg : 32'sd0;
            full_out_reg   <= full_reg && (op_reg == pltq_pkg::OP_LOAD);
        end
    end

    assign status.walk_done = (walk_reg >= count_reg);
    assign status.hit_ok    = contain && !flat;
    assign status.div_last  = (dcnt_reg == pltq_pkg::DCNT_W'(pltq_pkg::DIV_STEPS - 1));
    assign status.out_busy  = out_valid_reg && !out_ready;

    assign found      = found_out_reg;
    assign height     = height_out_reg;
    assign table_full = full_out_reg;
    assign out_valid  = out_valid_reg;

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_MAX)
        else $error("plate count above capacity");

    a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd |-> walk_reg < count_reg)
        else $error("read past stored plates");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mem_wr && tbl_full) |=> $stable(count_reg))
        else $error("count moved on dropped load");

endmodule

/* rtl/plate_height_query.sv */
// Plate height query: plate table with highest-plane lookup at a point.
// out_valid rises after the transfer. A load writes the table (S_LOAD), clear and unused
// codes go straight to S_FIN, and a query checks each stored plate; each usable hit uses
// the shared multiplier (3 passes) and 2-bit/cycle divider (23 passes). One item at a
// time; a new item is taken while the last result waits. Reset (rst_n low, async) empties
// the table and drops any pending result. Depends on pltq_pkg, pltq_ctrl, pltq_datapath.
module plate_height_query #(
    parameter int MAX_PLATES = pltq_pkg::MAX_PLATES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         op,
    input  logic signed [15:0] plate_x,
    input  logic signed [15:0] plate_y,
    input  logic signed [16:0] plate_w,
    input  logic signed [16:0] plate_h,
    input  logic signed [31:0] plane_dist,
    input  logic signed [13:0] normal_x,
    input  logic signed [13:0] normal_y,
    input  logic signed [13:0] normal_z,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               found,
    output logic signed [31:0] height,
    output logic               table_full
);

    pltq_pkg::cmd_t    cmd;
    pltq_pkg::status_t status;

    pltq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .op       (op),
        .status   (status),
        .cmd      (cmd)
    );

    pltq_datapath #(
        .MAX_PLATES (MAX_PLATES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .plate_x    (plate_x),
        .plate_y    (plate_y),
        .plate_w    (plate_w),
        .plate_h    (plate_h),
        .plane_dist (plane_dist),
        .normal_x   (normal_x),
        .normal_y   (normal_y),
        .normal_z   (normal_z),
        .point_x    (point_x),
        .point_y    (point_y),
        .cmd        (cmd),
        .status     (status),
        .found      (found),
        .height     (height),
        .table_full (table_full),
        .out_valid  (out_valid),
        .out_ready  (out_ready)
    );

endmodule

/* dv/tb_plate_height_query.sv */
// Testbench for plate_height_query: random and directed load/query/clear traffic,
// results checked against an in-bench plate table predictor. Depends on pltq_pkg.
module tb_plate_height_query;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPLATES = 256;
    localparam logic signed [63:0] UNIT_Q16 = 64'sd268406782;
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic               found;
        logic signed [31:0] height;
        logic               table_full;
    } hq_result_t;

    typedef struct {
        logic signed [31:0] x0, x1, y0, y1, plane;
        logic signed [13:0] nx, ny, nz;
    } plate_rec_t;

    class plate_scoreboard;
        plate_rec_t   plates[NPLATES];
        int           count;
        hq_result_t   pending[$];
        int           errors;
        int           n_found, n_full, n_queries;

        function void note_item(logic [1:0] op_i, logic signed [15:0] px, logic signed [15:0] py,
                                logic signed [16:0] pw, logic signed [16:0] ph,
                                logic signed [31:0] d, logic signed [13:0] sx,
                                logic signed [13:0] sy, logic signed [13:0] sz,
                                logic signed [31:0] x, logic signed [31:0] y);
            hq_result_t r;
            longint qx, qy, num, h, best;
            r = '0;
            best = 0;
            if (op_i == pltq_pkg::OP_LOAD) begin
                if (count < NPLATES) begin
                    qx = longint'(px) + longint'(pw);
                    qy = longint'(py) + longint'(ph);
                    plates[count].x0 = 32'((longint'(px) < qx) ? longint'(px) : qx);
                    plates[count].x1 = 32'((longint'(px) < qx) ? qx : longint'(px));
                    plates[count].y0 = 32'((longint'(py) < qy) ? longint'(py) : qy);
                    plates[count].y1 = 32'((longint'(py) < qy) ? qy : longint'(py));
                    plates[count].plane = d;
                    plates[count].nx = sx;
                    plates[count].ny = sy;
                    plates[count].nz = sz;
                    count++;
                end
                else
                begin
                    r.table_full = 1'b1;
                    n_full++;
                end
            end
            else if (op_i == pltq_pkg::OP_QUERY) begin
                n_queries++;
                for (int i = 0; i < count; i++) begin
                    if (longint'(x) < longint'(plates[i].x0) * 65536 ||
                        longint'(x) > longint'(plates[i].x1) * 65536 ||
                        longint'(y) < longint'(plates[i].y0) * 65536 ||
                        longint'(y) > longint'(plates[i].y1) * 65536)
                        continue;
                    if (plates[i].nz >= -pltq_pkg::FLAT_LIMIT &&
                        plates[i].nz <= pltq_pkg::FLAT_LIMIT)
                        continue;
                    num = longint'(plates[i].plane) * UNIT_Q16
                        - (longint'(plates[i].nx) * longint'(x)
                           + longint'(plates[i].ny) * longint'(y)) * 65536;
                    h = num / (longint'(plates[i].nz) * 65536);
                    if (!r.found || h > best)
                    begin
                        best = h;
                        r.found = 1'b1;
                    end
                end
                if (best > 64'sd2147483647) best = 64'sd2147483647;
                if (best < -64'sd2147483648) best = -64'sd2147483648;
                if (r.found)
                begin
                    r.height = best[31:0];
                    n_found++;
                end
            end
            else if (op_i == pltq_pkg::OP_CLEAR) begin
                count = 0;
            end
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(logic f, logic signed [31:0] ht, logic tf);
            hq_result_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result: found=%0d height=%0d table_full=%0d", f, ht, tf);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (f !== e.found)
            begin
                $error("found: expected %0d actual %0d", e.found, f);
                errors++;
            end
            if (ht !== e.height)
            begin
                $error("height: expected %0d actual %0d", e.height, ht);
                errors++;
            end
            if (tf !== e.table_full)
            begin
                $error("table_full: expected %0d actual %0d", e.table_full, tf);
                errors++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         op = '0;
    logic signed [15:0] plate_x = '0, plate_y = '0;
    logic signed [16:0] plate_w = '0, plate_h = '0;
    logic signed [31:0] plane_dist = '0;
    logic signed [13:0] normal_x = '0, normal_y = '0, normal_z = '0;
    logic signed [31:0] point_x = '0, point_y = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               found;
    logic signed [31:0] height;
    logic               table_full;

    plate_scoreboard sb;
    bit  stim_done = 0;
    bit  hold_off = 0;
    int  n_items = 0;

    plate_height_query uut (.*);

    always #10 clk = ~clk;

    initial
    begin
        #1s;
        $display("plate_height_query regression: fail");
        $finish;
    end

    function automatic int gap_len();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    endfunction

    task automatic send_item(logic [1:0] o, logic signed [15:0] px, logic signed [15:0] py,
                             logic signed [16:0] pw, logic signed [16:0] ph,
                             logic signed [31:0] d, logic signed [13:0] sx,
                             logic signed [13:0] sy, logic signed [13:0] sz,
                             logic signed [31:0] x, logic signed [31:0] y, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        plate_x <= px; plate_y <= py; plate_w <= pw; plate_h <= ph;
        plane_dist <= d;
        normal_x <= sx; normal_y <= sy; normal_z <= sz;
        point_x <= x; point_y <= y;
        do @(posedge clk); while (!in_ready);
        sb.note_item(o, px, py, pw, ph, d, sx, sy, sz, x, y);
        n_items++;
    endtask

    function automatic logic signed [13:0] rnd_normal();
        case ($urandom_range(0, 5))
            0: return 14'($urandom_range(0, 8)) - 14'sd4;
            1: return ($urandom_range(0, 1)) ? 14'sd4096 : -14'sd4096;
            2: return 14'($urandom);
            default: return 14'($urandom_range(0, 8192)) - 14'sd4096;
        endcase
    endfunction

    // random load, mostly small plates near the origin so queries hit
    task automatic rand_load(bit gaps);
        logic signed [15:0] px, py;
        logic signed [16:0] pw, ph;
        if ($urandom_range(0, 9) == 0)
        begin
            px = 16'($urandom); py = 16'($urandom);
            pw = 17'($urandom); ph = 17'($urandom);
        end
        else
        begin
            px = 16'($urandom_range(0, 64)) - 16'sd32;
            py = 16'($urandom_range(0, 64)) - 16'sd32;
            pw = 17'($urandom_range(0, 80)) - 17'sd40;
            ph = 17'($urandom_range(0, 80)) - 17'sd40;
        end
        send_item(pltq_pkg::OP_LOAD, px, py, pw, ph, 32'($urandom), rnd_normal(), rnd_normal(),
                  rnd_normal(), 32'($urandom), 32'($urandom), gaps);
    endtask

    task automatic rand_query(bit gaps);
        logic signed [31:0] x, y;
        if ($urandom_range(0, 7) == 0)
        begin
            x = 32'($urandom); y = 32'($urandom);
        end
        else
        begin
            x = 32'($urandom_range(0, 64 * 65536)) - 32'sd2097152;
            y = 32'($urandom_range(0, 64 * 65536)) - 32'sd2097152;
            if ($urandom_range(0, 3) == 0) x = {x[31:16], 16'h0};
        end
        send_item(pltq_pkg::OP_QUERY, 16'($urandom), 16'($urandom), 17'($urandom),
                  17'($urandom), 32'($urandom), 14'($urandom), 14'($urandom), 14'($urandom),
                  x, y, gaps);
    endtask

    task automatic send_clear(logic [1:0] o);
        send_item(o, 16'($urandom), 16'($urandom), 17'($urandom), 17'($urandom),
                  32'($urandom), 14'($urandom), 14'($urandom), 14'($urandom),
                  32'($urandom), 32'($urandom), 1);
    endtask

    // receiver: random stalls, occasional long ones, plus one long hold-off
    initial
    begin
        int stall;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off || stall > 0)
            begin
                out_ready <= 1'b0;
                if (stall > 0)
                    stall--;
            end
            else if ($urandom_range(0, 49) == 0)
            begin
                stall = $urandom_range(8, 40);
                out_ready <= 1'b0;
            end
            else if ($urandom_range(0, 2) == 0)
                out_ready <= ($urandom_range(0, 9) == 0) ? 1'b0 : ($urandom_range(0, 1) == 1);
            else
                out_ready <= 1'b1;
            if (out_valid && out_ready)
                sb.check_result(found, height, table_full);
        end
    end

    initial
    begin
        @(posedge rst_n);
        repeat (200) @(posedge clk);
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
    end

    initial
    begin
        int wait_cnt;
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, extremes, flat normals, overflow, unused code
        rand_query(0);
        send_item(pltq_pkg::OP_LOAD, 16'sh7fff, 16'sh8000, -17'sd65535, 17'sd65535,
                  32'sh7fffffff, -14'sd4096, 14'sd4096, 14'sd5, 0, 0, 0);
        send_item(pltq_pkg::OP_LOAD, 16'sh8000, 16'sh7fff, 17'sd65535, -17'sd65535,
                  32'sh80000000, 14'sd4096, -14'sd4096, -14'sd5, 0, 0, 0);
        send_item(pltq_pkg::OP_LOAD, 0, 0, 17'sd10, 17'sd10, 32'sd65536, 0, 0, 14'sd4,
                  0, 0, 0);
        send_item(pltq_pkg::OP_LOAD, 0, 0, -17'sd10, -17'sd10, 32'sd65536, 0, 0, -14'sd4,
                  0, 0, 0);
        send_item(pltq_pkg::OP_LOAD, 0, 0, 17'sd10, 17'sd10, -32'sd65536, 14'sd100, 14'sd7,
                  14'sd4096, 0, 0, 0);
        send_item(pltq_pkg::OP_LOAD, 0, 0, 0, 0, 32'sd1, 14'sh1fff, 14'sh2000, 14'sh2000,
                  0, 0, 0);
        send_item(pltq_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(pltq_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 32'sd655360, 32'sd655360, 0);
        send_item(pltq_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 32'sd655361, 0, 0);
        send_item(pltq_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 32'sh7fffffff, 32'sh80000000, 0);
        send_item(pltq_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 32'sh80000000, 32'sh7fffffff, 0);
        send_item(pltq_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, -32'sd1, -32'sd1, 0);
        send_clear(OP_SPARE);
        send_clear(pltq_pkg::OP_CLEAR);
        rand_query(0);
        // fill past capacity
        for (int i = 0; i < NPLATES + 3; i++) rand_load(i > 100);
        for (int i = 0; i < 6; i++) rand_query(0);
        send_clear(pltq_pkg::OP_CLEAR);

        // random: well-formed batches of loads then queries
        while (n_items < 1170)
        begin
            int nl;
            nl = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
            for (int i = 0; i < nl; i++) rand_load(1);
            for (int i = $urandom_range(2, 12); i > 0; i--)
            begin
                case ($urandom_range(0, 19))
                    0: send_clear(OP_SPARE);
                    1: rand_load(1);
                    default: rand_query(1);
                endcase
            end
            send_clear(($urandom_range(0, 4) == 0) ? OP_SPARE : pltq_pkg::OP_CLEAR);
        end
        in_valid <= 1'b0;

        stim_done = 1;
        wait_cnt = 0;
        while (sb.pending.size() != 0 && wait_cnt < 200000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (50) @(posedge clk);
        $display("covered %0d items: %0d queries (%0d hit), %0d dropped loads",
                 n_items, sb.n_queries, sb.n_found, sb.n_full);
        if (sb.pending.size() != 0)
        begin
            $error("%0d results never arrived", sb.pending.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("plate_height_query regression: pass");
        else
            $display("plate_height_query regression: fail");
        $finish;
    end
endmodule
